>>> rtl/ternary_search_sorted_table_macros.svh
// Assertion macros for the ternary search block.
`ifndef TERNARY_SEARCH_SORTED_TABLE_MACROS_SVH
`define TERNARY_SEARCH_SORTED_TABLE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TSS_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TSS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tss_pkg.sv
// Shared types, constants and helpers of the ternary search block.
package tss_pkg;

    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;
    localparam int PTR_W  = IDX_W + 2;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    // floor(x/3) = (x * 683) >> 11 for x < 2048
    localparam logic [10:0] RECIP3 = 11'd683;

    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_t;

    function automatic logic [IDX_W-1:0] div3(input logic [IDX_W:0] x);
        logic [2*IDX_W+1:0] prod;
        prod = (2*IDX_W+2)'(x) * (2*IDX_W+2)'(RECIP3);
        return prod[2*IDX_W:IDX_W+1];
    endfunction

endpackage

>>> rtl/tss_table.sv
// Table storage: one write port, one registered read port.
module tss_table #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                               clk,
    input  logic                               we,
    input  logic [AW-1:0]                      waddr,
    input  logic signed [tss_pkg::DATA_W-1:0]  wdata,
    input  logic [AW-1:0]                      raddr,
    output logic signed [tss_pkg::DATA_W-1:0]  rdata_reg
);

    logic signed [tss_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

endmodule

>>> rtl/tss_cmp.sv
// Shared key comparator used for every pivot probe.
module tss_cmp (
    input  logic signed [tss_pkg::DATA_W-1:0] key,
    input  logic signed [tss_pkg::DATA_W-1:0] value,
    output tss_pkg::cmp_t                     result
);

    always_comb
    begin
        result.eq = (key == value);
        result.lt = (key < value);
    end

endmodule

>>> rtl/tss_ctrl.sv
// Search sequencer: pivot arithmetic, probe order, narrowing and result register.
module tss_ctrl #(
    parameter int DEPTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [tss_pkg::DATA_W-1:0]  search_key,
    input  logic [tss_pkg::IDX_W-1:0]          range_first,
    input  logic [tss_pkg::IDX_W-1:0]          range_last,
    input  tss_pkg::cmp_t                      cmp,
    input  logic                               rsp_stall,
    output logic                               busy,
    output logic signed [tss_pkg::DATA_W-1:0]  key,
    output logic [tss_pkg::IDX_W-1:0]          rd_idx,
    output logic                               rsp_valid,
    output logic                               found,
    output logic [tss_pkg::IDX_W-1:0]          found_index
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CALC = 3'd1;
    localparam logic [2:0] ST_RD0  = 3'd2;
    localparam logic [2:0] ST_RD1  = 3'd3;
    localparam logic [2:0] ST_CMP1 = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    localparam logic [16:0] DEPTH_V = 17'(DEPTH);
    localparam int PW = tss_pkg::PTR_W;
    localparam int IW = tss_pkg::IDX_W;

    logic [2:0]                         state_reg, state_next;
    logic signed [PW-1:0]               lo_reg, lo_next;
    logic signed [PW-1:0]               hi_reg, hi_next;
    logic signed [PW-1:0]               p0_reg, p0_next;
    logic signed [PW-1:0]               p1_reg, p1_next;
    logic                               small_reg, small_next;
    logic                               eq0_reg, eq0_next;
    logic                               lt0_reg, lt0_next;
    logic                               hit_reg, hit_next;
    logic [IW-1:0]                      hit_idx_reg, hit_idx_next;
    logic signed [tss_pkg::DATA_W-1:0]  key_reg, key_next;
    logic                               rsp_valid_reg, rsp_valid_next;
    logic                               found_reg, found_next;
    logic [IW-1:0]                      found_index_reg, found_index_next;

    logic signed [PW-1:0]               span;
    logic [IW-1:0]                      third;
    logic [IW-1:0]                      two_third;

    always_comb
    begin
        span      = hi_reg - lo_reg;
        third     = tss_pkg::div3({1'b0, span[IW-1:0]});
        two_third = tss_pkg::div3({span[IW-1:0], 1'b0});
    end

    always_comb
    begin
        state_next       = state_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        p0_next          = p0_reg;
        p1_next          = p1_reg;
        small_next       = small_reg;
        eq0_next         = eq0_reg;
        lt0_next         = lt0_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        key_next         = key_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        found_next       = found_reg;
        found_index_next = found_index_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next     = search_key;
                    lo_next      = $signed({2'b00, range_first});
                    hi_next      = $signed({2'b00, range_last});
                    hit_next     = 1'b0;
                    hit_idx_next = '0;
                    if (17'(range_last) < DEPTH_V)
                    begin
                        state_next = ST_CALC;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_CALC:
            begin
                if (span < 0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    small_next = (span < 2);
                    if (span < 2)
                    begin
                        p0_next = lo_reg;
                        p1_next = hi_reg;
                    end
                    else
                    begin
                        p0_next = lo_reg + $signed({2'b00, third});
                        p1_next = lo_reg + $signed({2'b00, two_third});
                    end
                    state_next = ST_RD0;
                end
            end
            ST_RD0:
            begin
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                eq0_next   = cmp.eq;
                lt0_next   = cmp.lt;
                state_next = ST_CMP1;
            end
            ST_CMP1:
            begin
                state_next = ST_CALC;
                if (eq0_reg)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = p0_reg[IW-1:0];
                    state_next   = ST_DONE;
                end
                else if (cmp.eq)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = p1_reg[IW-1:0];
                    state_next   = ST_DONE;
                end
                else if (small_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (lt0_reg)
                begin
                    hi_next = p0_reg - PW'(1);
                end
                else if (cmp.lt)
                begin
                    lo_next = p0_reg + PW'(1);
                    hi_next = p1_reg - PW'(1);
                end
                else
                begin
                    lo_next = p1_reg + PW'(1);
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next   = 1'b1;
                    found_next       = hit_reg;
                    found_index_next = hit_idx_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        p0_reg          <= p0_next;
        p1_reg          <= p1_next;
        small_reg       <= small_next;
        eq0_reg         <= eq0_next;
        lt0_reg         <= lt0_next;
        hit_reg         <= hit_next;
        hit_idx_reg     <= hit_idx_next;
        key_reg         <= key_next;
        found_reg       <= found_next;
        found_index_reg <= found_index_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign key         = key_reg;
    assign rd_idx      = (state_reg == ST_RD0) ? p0_reg[IW-1:0] : p1_reg[IW-1:0];
    assign rsp_valid   = rsp_valid_reg;
    assign found       = found_reg;
    assign found_index = found_index_reg;

endmodule

>>> rtl/ternary_search_sorted_table.sv
// Ternary search over a sorted table: top level.
// A write request (mode 0) stores entry_value at entry_index and gives
// no response; indexes at or past TABLE_DEPTH are dropped. A search request (mode 1)
// returns one response with found and found_index (0 when not found). Each narrowing
// round cuts the range to about a third; the round length is set by the single table
// read port, which fetches the two pivots one after the other, and the one key
// comparator they share. Requests stall while a search runs. The table has
// no reset: entries must be written before a search reaches them, and there is no
// clearing pass. The table is expected to be kept sorted ascending.
`include "ternary_search_sorted_table_macros.svh"

module ternary_search_sorted_table #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic                               mode,
    input  logic [tss_pkg::IDX_W-1:0]          entry_index,
    input  logic signed [tss_pkg::DATA_W-1:0]  entry_value,
    input  logic signed [tss_pkg::DATA_W-1:0]  search_key,
    input  logic [tss_pkg::IDX_W-1:0]          range_first,
    input  logic [tss_pkg::IDX_W-1:0]          range_last,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic                               found,
    output logic [tss_pkg::IDX_W-1:0]          found_index
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [16:0] DEPTH_V = 17'(TABLE_DEPTH);

    logic                               accept;
    logic                               wr_en;
    logic                               busy;
    logic signed [tss_pkg::DATA_W-1:0]  key;
    logic signed [tss_pkg::DATA_W-1:0]  rdata;
    logic [tss_pkg::IDX_W-1:0]          rd_idx;
    tss_pkg::cmp_t                      cmp;

    assign accept    = req_valid && !req_stall;
    assign wr_en     = accept && (mode == tss_pkg::MODE_WRITE)
                       && (17'(entry_index) < DEPTH_V);
    assign req_stall = busy;

    tss_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk       (clk),
        .we        (wr_en),
        .waddr     (AW'(entry_index)),
        .wdata     (entry_value),
        .raddr     (AW'(rd_idx)),
        .rdata_reg (rdata)
    );

    tss_cmp u_cmp (
        .key    (key),
        .value  (rdata),
        .result (cmp)
    );

    tss_ctrl #(
        .DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept && (mode == tss_pkg::MODE_SEARCH)),
        .search_key  (search_key),
        .range_first (range_first),
        .range_last  (range_last),
        .cmp         (cmp),
        .rsp_stall   (rsp_stall),
        .busy        (busy),
        .key         (key),
        .rd_idx      (rd_idx),
        .rsp_valid   (rsp_valid),
        .found       (found),
        .found_index (found_index)
    );

    `TSS_ASSERT_NEXT(a_search_busy, clk, rst_n, accept && (mode == tss_pkg::MODE_SEARCH), req_stall, "search not started")
    `TSS_ASSERT_NEXT(a_write_silent, clk, rst_n, accept && (mode == tss_pkg::MODE_WRITE) && !rsp_valid, !rsp_valid, "write gave a response")
    `TSS_ASSERT_NOW(a_miss_index, clk, rst_n, rsp_valid && !found, found_index == '0, "miss with nonzero index")

endmodule

>>> dv/ternary_search_sorted_table_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the ternary search sorted table block.
module ternary_search_sorted_table_tb;

    localparam int IDX_W  = tss_pkg::IDX_W;
    localparam int DATA_W = tss_pkg::DATA_W;

    localparam int TABLE_DEPTH   = 1024;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 64;

    localparam logic MODE_WRITE  = tss_pkg::MODE_WRITE;
    localparam logic MODE_SEARCH = tss_pkg::MODE_SEARCH;

    localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] pos;
    } lookup_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_stall;
    logic                     mode;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] search_key;
    logic [IDX_W-1:0]         range_first;
    logic [IDX_W-1:0]         range_last;
    logic                     rsp_valid;
    logic                     rsp_stall;
    logic                     found;
    logic [IDX_W-1:0]         found_index;

    logic signed [DATA_W-1:0] entry_mirror [TABLE_DEPTH];
    lookup_t                  pending_results [$];

    int req_idle_pct;
    int rsp_idle_pct;
    int quiet_cycles;
    int mismatches;
    int write_count;
    int search_count;
    int hit_count;
    int reversed_count;
    int unsorted_writes;

    ternary_search_sorted_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .mode       (mode),
        .entry_index(entry_index),
        .entry_value(entry_value),
        .search_key (search_key),
        .range_first(range_first),
        .range_last (range_last),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .found      (found),
        .found_index(found_index)
    );

    always #2 clk = ~clk;

    // Probe sequence of the block, run over the mirrored table.
    function automatic lookup_t ternary_lookup(input logic signed [DATA_W-1:0] key,
                                               input logic [IDX_W-1:0] first,
                                               input logic [IDX_W-1:0] last);
        lookup_t                  r;
        int                       lo;
        int                       hi;
        int                       span;
        int                       lp;
        int                       rp;
        logic signed [DATA_W-1:0] lv;
        logic signed [DATA_W-1:0] rv;
        logic                     done;
        r    = '0;
        lo   = int'(first);
        hi   = int'(last);
        done = (hi >= TABLE_DEPTH);
        while (!done)
        begin
            span = hi - lo;
            if (span >= 2)
            begin
                lp = lo + span / 3;
                rp = lo + (2 * span) / 3;
                lv = entry_mirror[lp];
                rv = entry_mirror[rp];
                if (key == lv)
                begin
                    r.hit = 1'b1;
                    r.pos = IDX_W'(lp);
                    done  = 1'b1;
                end
                else if (key == rv)
                begin
                    r.hit = 1'b1;
                    r.pos = IDX_W'(rp);
                    done  = 1'b1;
                end
                else if (key < lv)
                    hi = lp - 1;
                else if (key < rv)
                begin
                    lo = lp + 1;
                    hi = rp - 1;
                end
                else
                    lo = rp + 1;
            end
            else
            begin
                if (span >= 0 && entry_mirror[lo] == key)
                begin
                    r.hit = 1'b1;
                    r.pos = IDX_W'(lo);
                end
                else if (span == 1 && entry_mirror[hi] == key)
                begin
                    r.hit = 1'b1;
                    r.pos = IDX_W'(hi);
                end
                done = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic send_request(input logic op,
                                input logic [IDX_W-1:0] wr_idx,
                                input logic signed [DATA_W-1:0] wr_val,
                                input logic signed [DATA_W-1:0] key,
                                input logic [IDX_W-1:0] first,
                                input logic [IDX_W-1:0] last);
        lookup_t res;
        while ($urandom_range(0, 99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid   <= 1'b1;
        mode        <= op;
        entry_index <= wr_idx;
        entry_value <= wr_val;
        search_key  <= key;
        range_first <= first;
        range_last  <= last;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (op == MODE_WRITE)
        begin
            if (wr_idx < TABLE_DEPTH)
                entry_mirror[wr_idx] = wr_val;
            write_count++;
        end
        else
        begin
            res = ternary_lookup(key, first, last);
            pending_results = {pending_results, res};
            search_count++;
            if (res.hit)
                hit_count++;
            if (first > last)
                reversed_count++;
        end
    endtask

    // Unused fields carry random values.
    task automatic write_entry(input logic [IDX_W-1:0] idx,
                               input logic signed [DATA_W-1:0] val);
        send_request(MODE_WRITE, idx, val, $urandom, IDX_W'($urandom), IDX_W'($urandom));
    endtask

    task automatic search(input logic signed [DATA_W-1:0] key,
                          input logic [IDX_W-1:0] first,
                          input logic [IDX_W-1:0] last);
        send_request(MODE_SEARCH, IDX_W'($urandom), $urandom, key, first, last);
    endtask

    task automatic hold_until_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Ordered ranges stay inside [0, top], which is written; reversed ranges may reach past top but read nothing.
    task automatic random_search(input int top);
        int                       first;
        int                       last;
        int                       pick;
        int                       k;
        logic signed [DATA_W-1:0] key;
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            last  = $urandom_range(0, TABLE_DEPTH - 2);
            first = $urandom_range(last + 1, TABLE_DEPTH - 1);
        end
        else if (pick < 16)
        begin
            first = 0;
            last  = top;
        end
        else if (pick < 36)
        begin
            first = $urandom_range(0, top);
            last  = first + $urandom_range(0, 3);
            if (last > top)
                last = top;
        end
        else
        begin
            first = $urandom_range(0, top);
            last  = $urandom_range(first, top);
        end
        if (first <= last)
            k = $urandom_range(first, last);
        else
            k = $urandom_range(0, top);
        key  = entry_mirror[k];
        pick = $urandom_range(0, 99);
        if (pick >= 95)
            key = $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
        else if (pick >= 80)
            key = $urandom;
        else if (pick >= 60)
            key = key + ($urandom_range(0, 1) ? 1 : -1);
        search(key, IDX_W'(first), IDX_W'(last));
    endtask

    // Mostly order-preserving overwrites; one in four writes a random value, which can break the order.
    task automatic random_update();
        int     idx;
        longint floor_v;
        longint ceil_v;
        idx = $urandom_range(0, TABLE_DEPTH - 1);
        if ($urandom_range(0, 3) == 0)
        begin
            unsorted_writes++;
            write_entry(IDX_W'(idx), $urandom);
        end
        else
        begin
            floor_v = longint'((idx > 0) ? entry_mirror[idx - 1] : VALUE_MIN);
            ceil_v  = longint'((idx < TABLE_DEPTH - 1) ? entry_mirror[idx + 1] : VALUE_MAX);
            if (ceil_v < floor_v)
                ceil_v = floor_v;
            write_entry(IDX_W'(idx),
                        DATA_W'(floor_v + longint'($urandom_range(0, 32'(ceil_v - floor_v)))));
        end
    endtask

    task automatic random_mix(input int count, input int drain_every);
        int n;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 20)
                random_update();
            else
                random_search(TABLE_DEPTH - 1);
            if (n % drain_every == drain_every - 1)
                hold_until_drained();
        end
    endtask

    task automatic test_directed();
        logic signed [DATA_W-1:0] seed_vals [10];
        int                       i;
        seed_vals = '{VALUE_MIN, -1000, -5, 0, 3, 7, 100, 5000, 70000, VALUE_MAX};
        for (i = 0; i < 10; i++)
            write_entry(IDX_W'(i), seed_vals[i]);
        write_entry(IDX_W'(TABLE_DEPTH - 1), VALUE_MAX);
        search(VALUE_MIN, IDX_W'(0), IDX_W'(9));
        search(VALUE_MAX, IDX_W'(0), IDX_W'(9));
        search(0, IDX_W'(0), IDX_W'(9));
        search(100, IDX_W'(0), IDX_W'(9));
        search(3, IDX_W'(4), IDX_W'(5));
        search(7, IDX_W'(4), IDX_W'(5));
        search(4, IDX_W'(4), IDX_W'(5));
        search(VALUE_MAX, IDX_W'(TABLE_DEPTH - 1), IDX_W'(TABLE_DEPTH - 1));
        search(VALUE_MIN, IDX_W'(TABLE_DEPTH - 1), IDX_W'(TABLE_DEPTH - 1));
        search(0, IDX_W'(TABLE_DEPTH - 1), IDX_W'(0));
        search(6, IDX_W'(0), IDX_W'(9));
        // out-of-order entry
        write_entry(IDX_W'(2), VALUE_MAX);
        search(VALUE_MAX, IDX_W'(0), IDX_W'(9));
        search(-5, IDX_W'(0), IDX_W'(9));
    endtask

    // Sorted fill in index order, searching the written prefix along the way.
    task automatic test_fill_with_searches();
        longint level;
        int     i;
        level = longint'(VALUE_MIN) + $urandom_range(0, 3);
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            if (i > 0 && $urandom_range(0, 15) != 0)
                level += $urandom_range(1, 8000000);
            if (level > longint'(VALUE_MAX))
                level = longint'(VALUE_MAX);
            write_entry(IDX_W'(i), DATA_W'(level));
            if (i % 8 == 7)
                random_search(i);
        end
    endtask

    task automatic test_random_mix();
        random_mix(380, 60);
    endtask

    task automatic test_back_to_back();
        random_mix(270, 1000);
    endtask

    always @(posedge clk)
    begin : check_results
        lookup_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("response with no search outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (found !== want.hit)
                    begin
                        $error("found: expected %0b, got %0b", want.hit, found);
                        mismatches++;
                    end
                    if (found_index !== want.pos)
                    begin
                        $error("found_index: expected %0d, got %0d", want.pos, found_index);
                        mismatches++;
                    end
                end
            end
            rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("ternary_search_sorted_table_tb failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        req_valid       = 1'b0;
        mode            = MODE_WRITE;
        entry_index     = '0;
        entry_value     = '0;
        search_key      = '0;
        range_first     = '0;
        range_last      = '0;
        write_count     = 0;
        search_count    = 0;
        hit_count       = 0;
        reversed_count  = 0;
        unsorted_writes = 0;
        req_idle_pct    = 37;
        rsp_idle_pct    = 73;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_with_searches();
        hold_until_drained();

        req_idle_pct = 73;
        rsp_idle_pct = 37;
        test_random_mix();
        hold_until_drained();

        req_idle_pct = 0;
        rsp_idle_pct = 0;
        test_back_to_back();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d table writes and %0d searches (%0d hits, %0d reversed ranges).",
                 write_count, search_count, hit_count, reversed_count);
        $display("Three stall mixes; %0d overwrites left the table out of order.",
                 unsorted_writes);
        if (mismatches == 0)
            $display("ternary_search_sorted_table_tb passed");
        else
            $display("ternary_search_sorted_table_tb failed");
        $finish;
    end

endmodule
